// ----- design/hbd_pkg.sv -----
// ----------------------------------------------------------------------------
// HDLC bit deframer package
// Shared constants, event codes and the result record of the deframer.
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int LENGTH_WIDTH = 16;

    localparam logic [7:0] FLAG_PATTERN  = 8'h7E;
    localparam logic [2:0] STUFF_RUN     = 3'd5;
    localparam logic [2:0] ABORT_RUN     = 3'd6;
    localparam logic [2:0] ONES_MAX      = 3'd7;
    localparam logic [2:0] LAST_BIT_POS  = 3'd7;
    localparam logic [7:0] MIN_LEN_RESET = 8'd4;

    localparam logic [1:0] EV_DATA  = 2'd0;
    localparam logic [1:0] EV_CLOSE = 2'd1;
    localparam logic [1:0] EV_ABORT = 2'd2;

    typedef logic [LENGTH_WIDTH-1:0] count_t;

    localparam count_t COUNT_MAX = '1;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
        logic        long_enough;
    } result_t;

endpackage

// ----- design/hbd_bit_if.sv -----
// ----------------------------------------------------------------------------
// Line bit channel
// Valid/ready channel that carries one raw received bit per request.
// ----------------------------------------------------------------------------
interface hbd_bit_if;

    logic valid;
    logic ready;
    logic line_bit;

    modport source (output valid, output line_bit, input ready);
    modport sink   (input valid, input line_bit, output ready);

endinterface

// ----- design/hbd_event_if.sv -----
// ----------------------------------------------------------------------------
// Deframer event channel
// Valid/ready channel that carries data bytes, frame closes and aborts.
// ----------------------------------------------------------------------------
interface hbd_event_if;

    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
    logic        long_enough;

    modport source (
        output valid, output event_kind, output data_byte,
        output frame_length, output long_enough, input ready
    );
    modport sink (
        input valid, input event_kind, input data_byte,
        input frame_length, input long_enough, output ready
    );

endinterface

// ----- design/hbd_in_reg.sv -----
// ----------------------------------------------------------------------------
// Deframer input register
// Holds one accepted line bit until the step logic consumes it.
// ----------------------------------------------------------------------------
module hbd_in_reg (
    input  logic       clk,
    input  logic       rst_n,
    hbd_bit_if.sink    bits,
    input  logic       advance,
    output logic       bit_valid,
    output logic       line_bit
);

    logic valid_reg;
    logic valid_next;
    logic bit_reg;
    logic accept;

    // Take a new request whenever the held bit is empty or leaves this cycle.
    assign bits.ready = !valid_reg || advance;
    assign accept     = bits.valid && bits.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bit_reg <= bits.line_bit;
        end
    end

    assign bit_valid = valid_reg;
    assign line_bit  = bit_reg;

endmodule

// ----- design/hbd_step.sv -----
// ----------------------------------------------------------------------------
// Deframer step logic
// Flag search, zero-bit destuffing, byte packing and frame counting for one
// line bit; holds the deframer state and the minimum length register.
// ----------------------------------------------------------------------------
module hbd_step (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [7:0]       cfg_wr_data,
    input  logic             advance,
    input  logic             line_bit,
    output logic             has_result,
    output hbd_pkg::result_t result
);

    logic [7:0]      min_len_reg;
    logic [7:0]      raw_shift_reg;
    logic [7:0]      raw_shift_next;
    logic            inside_reg;
    logic            inside_next;
    logic [2:0]      ones_run_reg;
    logic [2:0]      ones_run_next;
    logic [7:0]      acc_reg;
    logic [7:0]      acc_next;
    logic [2:0]      bit_cnt_reg;
    logic [2:0]      bit_cnt_next;
    hbd_pkg::count_t count_reg;
    hbd_pkg::count_t count_next;
    logic [7:0]      shift_new;
    logic [7:0]      acc_new;

    assign shift_new = {raw_shift_reg[6:0], line_bit};
    assign acc_new   = {acc_reg[6:0], line_bit};

    always_comb
    begin
        raw_shift_next      = shift_new;
        inside_next         = inside_reg;
        ones_run_next       = ones_run_reg;
        acc_next            = acc_reg;
        bit_cnt_next        = bit_cnt_reg;
        count_next          = count_reg;
        has_result          = 1'b0;
        result.event_kind   = hbd_pkg::EV_DATA;
        result.data_byte    = 8'd0;
        result.frame_length = 16'd0;
        result.long_enough  = 1'b0;

        if (inside_reg && (ones_run_reg > hbd_pkg::ABORT_RUN))
        begin
            // Too many ones: this bit is swallowed by the abort.
            inside_next       = 1'b0;
            ones_run_next     = 3'd0;
            acc_next          = 8'd0;
            bit_cnt_next      = 3'd0;
            count_next        = '0;
            has_result        = 1'b1;
            result.event_kind = hbd_pkg::EV_ABORT;
        end
        else if (shift_new == hbd_pkg::FLAG_PATTERN)
        begin
            // Close any open frame, drop the partial byte, open a new frame.
            has_result          = inside_reg;
            result.event_kind   = hbd_pkg::EV_CLOSE;
            result.frame_length = 16'(count_reg);
            result.long_enough  = (count_reg >= hbd_pkg::count_t'(min_len_reg));
            inside_next         = 1'b1;
            ones_run_next       = 3'd0;
            acc_next            = 8'd0;
            bit_cnt_next        = 3'd0;
            count_next          = '0;
        end
        else if (inside_reg)
        begin
            if (line_bit)
            begin
                if (ones_run_reg != hbd_pkg::ONES_MAX)
                begin
                    ones_run_next = ones_run_reg + 3'd1;
                end
            end
            else
            begin
                ones_run_next = 3'd0;
            end

            // A zero after exactly five ones is stuffing: drop it.
            if (line_bit || (ones_run_reg != hbd_pkg::STUFF_RUN))
            begin
                if (bit_cnt_reg == hbd_pkg::LAST_BIT_POS)
                begin
                    acc_next         = 8'd0;
                    bit_cnt_next     = 3'd0;
                    has_result       = 1'b1;
                    result.data_byte = acc_new;
                    if (count_reg != hbd_pkg::COUNT_MAX)
                    begin
                        count_next = count_reg + hbd_pkg::count_t'(1);
                    end
                end
                else
                begin
                    acc_next     = acc_new;
                    bit_cnt_next = bit_cnt_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= hbd_pkg::MIN_LEN_RESET;
            raw_shift_reg <= 8'd0;
            inside_reg    <= 1'b0;
            ones_run_reg  <= 3'd0;
            acc_reg       <= 8'd0;
            bit_cnt_reg   <= 3'd0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                min_len_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                raw_shift_reg <= raw_shift_next;
                inside_reg    <= inside_next;
                ones_run_reg  <= ones_run_next;
                acc_reg       <= acc_next;
                bit_cnt_reg   <= bit_cnt_next;
                count_reg     <= count_next;
            end
        end
    end

    // Outside a frame the frame state is always cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        !inside_reg |-> (ones_run_reg == 3'd0) && (bit_cnt_reg == 3'd0)
                        && (count_reg == '0))
        else $error("frame state not cleared outside a frame");

    // An abort leaves the block hunting for a flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_result && (result.event_kind == hbd_pkg::EV_ABORT)
        |=> !inside_reg)
        else $error("frame still open after abort");

    // A close reopens a fresh frame at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_result && (result.event_kind == hbd_pkg::EV_CLOSE)
        |=> inside_reg && (count_reg == '0) && (bit_cnt_reg == 3'd0))
        else $error("new frame not opened after close");

    // Each data byte below saturation bumps the byte count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_result && (result.event_kind == hbd_pkg::EV_DATA)
        && (count_reg != hbd_pkg::COUNT_MAX)
        |=> count_reg == $past(count_reg) + hbd_pkg::count_t'(1))
        else $error("byte count did not advance");

endmodule

// ----- design/hbd_out_reg.sv -----
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one event until the downstream side takes it.
// ----------------------------------------------------------------------------
module hbd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             has_result,
    input  hbd_pkg::result_t result,
    output logic             free,
    hbd_event_if.source      events
);

    logic             valid_reg;
    logic             valid_next;
    hbd_pkg::result_t result_reg;

    assign free = !valid_reg || events.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = has_result;
        end
        else if (events.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            result_reg <= result;
        end
    end

    assign events.valid        = valid_reg;
    assign events.event_kind   = result_reg.event_kind;
    assign events.data_byte    = result_reg.data_byte;
    assign events.frame_length = result_reg.frame_length;
    assign events.long_enough  = result_reg.long_enough;

endmodule

// ----- design/hdlc_bit_deframer.sv -----
// ----------------------------------------------------------------------------
// HDLC bit deframer
// Finds flags, removes stuffed zeros, packs bytes and reports frame closes
// and aborts, one line bit per cycle unless the event output stalls.
// Path: a bit waits in the input register, and its event in the result
// register, from which it is driven to the event ports.
// Throughput: single-pass step logic, one bit per cycle while out_free.
// Reset: rst_n clears the control state at once; min length returns to 4.
// ----------------------------------------------------------------------------
module hdlc_bit_deframer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    hbd_bit_if.sink      bits,
    hbd_event_if.source  events
);

    logic             bit_valid;
    logic             line_bit;
    logic             out_free;
    logic             advance;
    logic             has_result;
    hbd_pkg::result_t result;

    // Step a held bit whenever the result register can take its outcome.
    assign advance = bit_valid && out_free;

    hbd_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .bits      (bits),
        .advance   (advance),
        .bit_valid (bit_valid),
        .line_bit  (line_bit)
    );

    hbd_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .line_bit    (line_bit),
        .has_result  (has_result),
        .result      (result)
    );

    hbd_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .has_result (has_result),
        .result     (result),
        .free       (out_free),
        .events     (events)
    );

endmodule
